[rtl/sscp_pkg.sv]
// Shared types and constants of the serial servo command parser.
`default_nettype none
package sscp_pkg;

   // line buffer length and queue depth
   localparam int LINE_LENGTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   // character codes
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_X       = 8'h58;
   localparam logic [7:0] CHAR_Y       = 8'h59;

   // angle limits and magnitude saturation
   localparam logic [7:0] ANGLE_MAX = 8'd180;
   localparam logic [7:0] MAG_MAX   = 8'd255;

   // pulse = 500 + (100*angle)/9 ; duty = pulse*8191/20000
   localparam logic [6:0]  ANGLE_SCALE = 7'd100;
   localparam logic [13:0] RECIP_9     = 14'd14564;   // ceil(2^17/9)
   localparam logic [11:0] PULSE_MIN   = 12'd500;
   localparam logic [12:0] DUTY_SCALE  = 13'd8191;
   localparam logic [20:0] RECIP_625   = 21'd1717987; // ceil(2^30/625)

   // one decoded command waiting for the duty calculation
   typedef struct packed {
      logic       channel;
      logic [7:0] angle;
   } sscp_entry_type;

endpackage
`default_nettype wire

[rtl/sscp_if.sv]
// Handshake channels for received bytes and servo results.
`default_nettype none
interface sscp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sscp_rsp_if;
   logic       valid;
   logic       ready;
   logic       servo_channel;
   logic [9:0] duty_value;
   modport source (output valid, output servo_channel, output duty_value, input ready);
   modport sink (input valid, input servo_channel, input duty_value, output ready);
endinterface
`default_nettype wire

[rtl/sscp_front.sv]
// Line parser: axis letter, atoi-style number, command push on newline.
`default_nettype none
module sscp_front #(
   parameter int LINE_LENGTH = sscp_pkg::LINE_LENGTH_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   sscp_req_if.sink                     req,
   input  wire                          queue_full,
   output logic                         push,
   output sscp_pkg::sscp_entry_type     push_entry
);

   localparam int POS_W = $clog2(LINE_LENGTH);

   localparam logic [1:0] PHASE_SPACE  = 2'd0;
   localparam logic [1:0] PHASE_DIGITS = 2'd1;
   localparam logic [1:0] PHASE_DONE   = 2'd2;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       axis_ff, axis_in;
   logic [1:0]       phase_ff, phase_in;
   logic             neg_ff, neg_in;
   logic [7:0]       mag_ff, mag_in;

   logic             accept;
   logic [7:0]       b;
   logic             is_digit, is_space, is_sign;
   logic [11:0]      mag_next;
   logic [7:0]       mag_sat;
   logic [POS_W:0]   pos_inc;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;

   // byte classes
   assign is_digit = (b >= sscp_pkg::CHAR_ZERO) && (b <= sscp_pkg::CHAR_NINE);
   assign is_space = (b == sscp_pkg::CHAR_SPACE) ||
                     ((b >= sscp_pkg::CHAR_TAB) && (b <= sscp_pkg::CHAR_CR));
   assign is_sign  = (b == sscp_pkg::CHAR_PLUS) || (b == sscp_pkg::CHAR_MINUS);

   // magnitude*10 + digit, saturating
   assign mag_next = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1) +
                     {8'd0, b[3:0]};
   assign mag_sat  = (mag_next > {4'd0, sscp_pkg::MAG_MAX}) ? sscp_pkg::MAG_MAX
                                                            : mag_next[7:0];
   assign pos_inc  = {1'b0, pos_ff} + 1'b1;

   // command to the queue
   always_comb begin
      push               = accept && (b == sscp_pkg::CHAR_NEWLINE) && (pos_ff != '0) &&
                           ((axis_ff == sscp_pkg::CHAR_X) || (axis_ff == sscp_pkg::CHAR_Y));
      push_entry.channel = (axis_ff == sscp_pkg::CHAR_Y);
      if (neg_ff) begin
         push_entry.angle = 8'd0;
      end else if (mag_ff > sscp_pkg::ANGLE_MAX) begin
         push_entry.angle = sscp_pkg::ANGLE_MAX;
      end else begin
         push_entry.angle = mag_ff;
      end
   end

   // line state update
   always_comb begin
      pos_in   = pos_ff;
      axis_in  = axis_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      if (accept) begin
         if (b == sscp_pkg::CHAR_NEWLINE) begin
            pos_in   = '0;
            axis_in  = 8'd0;
            phase_in = PHASE_SPACE;
            neg_in   = 1'b0;
            mag_in   = 8'd0;
         end else if (pos_inc >= (POS_W+1)'(LINE_LENGTH)) begin
            // line full: wrap and start over
            pos_in   = '0;
            axis_in  = 8'd0;
            phase_in = PHASE_SPACE;
            neg_in   = 1'b0;
            mag_in   = 8'd0;
         end else begin
            pos_in = pos_inc[POS_W-1:0];
            if (pos_ff == '0) begin
               axis_in = b;
            end else begin
               unique case (phase_ff)
                  PHASE_SPACE: begin
                     if (is_sign) begin
                        neg_in   = (b == sscp_pkg::CHAR_MINUS);
                        phase_in = PHASE_DIGITS;
                     end else if (is_digit) begin
                        mag_in   = mag_sat;
                        phase_in = PHASE_DIGITS;
                     end else if (!is_space) begin
                        phase_in = PHASE_DONE;
                     end
                  end
                  PHASE_DIGITS: begin
                     if (is_digit) begin
                        mag_in = mag_sat;
                     end else begin
                        phase_in = PHASE_DONE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         axis_ff  <= 8'd0;
         phase_ff <= PHASE_SPACE;
         neg_ff   <= 1'b0;
         mag_ff   <= 8'd0;
      end else begin
         pos_ff   <= pos_in;
         axis_ff  <= axis_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
      end
   end

endmodule
`default_nettype wire

[rtl/sscp_queue.sv]
// Short command queue between parser and duty calculation.
`default_nettype none
module sscp_queue (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           push,
   input  wire sscp_pkg::sscp_entry_type push_entry,
   output logic                          full,
   output logic                          not_empty,
   input  wire                           pop,
   output sscp_pkg::sscp_entry_type      pop_entry
);

   localparam int DEPTH = sscp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sscp_pkg::sscp_entry_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = store_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

[rtl/sscp_back.sv]
// Duty calculation sequencer with output register.
`default_nettype none
module sscp_back (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           not_empty,
   input  wire sscp_pkg::sscp_entry_type pop_entry,
   output logic                          pop,
   sscp_rsp_if.source                    rsp
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV9  = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;

   logic [2:0]  state_ff, state_in;
   logic        chan_ff, chan_in;
   logic [14:0] x_ff, x_in;
   logic [11:0] pulse_ff, pulse_in;
   logic [24:0] y_ff, y_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_chan_ff, out_chan_in;
   logic [9:0]  out_duty_ff, out_duty_in;

   logic [28:0] prod9;
   logic [40:0] prod625;
   logic        out_free;

   assign rsp.valid         = out_valid_ff;
   assign rsp.servo_channel = out_chan_ff;
   assign rsp.duty_value    = out_duty_ff;
   assign out_free          = !out_valid_ff || rsp.ready;

   // reciprocal products: floor(x/9) and floor((y>>5)/625)
   assign prod9   = x_ff * sscp_pkg::RECIP_9;
   assign prod625 = y_ff[24:5] * sscp_pkg::RECIP_625;

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      x_in         = x_ff;
      pulse_in     = pulse_ff;
      y_in         = y_ff;
      out_chan_in  = out_chan_ff;
      out_duty_in  = out_duty_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               pop      = 1'b1;
               chan_in  = pop_entry.channel;
               x_in     = pop_entry.angle * sscp_pkg::ANGLE_SCALE;
               state_in = ST_DIV9;
            end
         end
         ST_DIV9: begin
            pulse_in = sscp_pkg::PULSE_MIN + {1'b0, prod9[27:17]};
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            y_in     = pulse_ff * sscp_pkg::DUTY_SCALE;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // hold until the output word is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_chan_in  = chan_ff;
               out_duty_in  = prod625[39:30];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      x_ff        <= x_in;
      pulse_ff    <= pulse_in;
      y_ff        <= y_in;
      out_chan_ff <= out_chan_in;
      out_duty_ff <= out_duty_in;
   end

endmodule
`default_nettype wire

[rtl/serial_servo_command_parser_top.sv]
// Top level of the serial servo command parser.
//
//   channel   direction  word fields
//   req_chan  in         rx_byte[7:0]
//   rsp_chan  out        servo_channel, duty_value[9:0]
//
// The parser takes one byte per cycle while the command queue has room.
// Each command passes the duty sequencer in order (pop and scale by 100,
// divide by nine, duty scale, divide and output load) before the next pop.
// Synchronous reset clears the line state, queue and output register.
// A stalled result holds the sequencer; the parser keeps taking bytes until
// the queue fills.
`default_nettype none
module serial_servo_command_parser_top #(
   parameter int LINE_LENGTH = sscp_pkg::LINE_LENGTH_DEFAULT
) (
   input wire         clock,
   input wire         reset,
   sscp_req_if.sink   req_chan,
   sscp_rsp_if.source rsp_chan
);

   logic                     queue_full;
   logic                     queue_not_empty;
   logic                     push;
   logic                     pop;
   sscp_pkg::sscp_entry_type push_entry;
   sscp_pkg::sscp_entry_type pop_entry;

   sscp_front #(
      .LINE_LENGTH (LINE_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   sscp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   sscp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (queue_not_empty),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule
`default_nettype wire
